// ===== hdl/buddy_page_allocator_top_defines.svh =====
// Assertion macros shared by the allocator RTL.
`ifndef BUDDY_PAGE_ALLOCATOR_TOP_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define BPA_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("bpa assertion failed");
`define BPA_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) else $error("bpa assertion failed");
`else
`define BPA_ASSERT(label, prop)
`define BPA_ASSERT_ALWAYS(label, prop)
`endif
`endif

// ===== hdl/bpa_pkg.sv =====
// Types, constants and helpers of the buddy page allocator.
`default_nettype none
package bpa_pkg;
   localparam int MAX_PAGES       = 1024;
   localparam int MAX_ORDERS      = 11;
   localparam int PAGE_SHIFT_BITS = 12;
   localparam int RECORD_DEPTH    = 2048;

   localparam int IDX_W   = $clog2(RECORD_DEPTH);
   localparam int CNT_W   = $clog2(RECORD_DEPTH + 1);
   localparam int PAGE_W  = 20;
   localparam int ORD_W   = $clog2(MAX_ORDERS + 1);
   localparam int REM_W   = $clog2(MAX_PAGES + 1);
   localparam int GUARD_W = $clog2(MAX_ORDERS + 3);
   localparam int ADDR_W  = 32;
   localparam int STAMP_W = 32;
   localparam int FUNC_W  = 2;
   localparam int REQ_W   = 11;
   localparam int STS_W   = 2;
   localparam int PCFG_W  = 11;
   localparam int OCFG_W  = 4;
   localparam int CSR_IDX_W = 2;
   localparam int BIG_W   = (MAX_ORDERS > REQ_W) ? MAX_ORDERS : REQ_W;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAGES  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORDERS = 2'd2;

   localparam logic [ADDR_W-1:0] BASE_RESET   = 32'h0100_0000;
   localparam logic [PCFG_W-1:0] PAGES_RESET  = 11'd1024;
   localparam logic [OCFG_W-1:0] ORDERS_RESET = 4'd11;

   typedef enum logic [1:0] {
      KIND_EMPTY, KIND_FREE, KIND_ALLOC, KIND_PARENT
   } kind_type;

   typedef enum logic [FUNC_W-1:0] {
      FN_INIT, FN_ALLOC, FN_FREE, FN_NOP
   } func_type;

   typedef enum logic [STS_W-1:0] {
      STS_OK, STS_BAD_SIZE, STS_NO_BLOCK, STS_NOT_ALLOC
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_LAYOUT, S_SCAN, S_DRAIN, S_EVAL, S_WR_P, S_WR_L,
      S_WR_R, S_RD_BUD, S_CHK, S_WR_CUR, S_LD_PAR, S_MKFREE
   } state_type;

   typedef enum logic [2:0] {
      PH_ALLOC_J, PH_ALLOC_K, PH_SPLIT, PH_FINAL, PH_FREE
   } phase_type;

   typedef struct packed {
      kind_type             kind;
      logic                 has_buddy;
      logic [PAGE_W-1:0]    page;
      logic [ORD_W-1:0]     order;
      logic [IDX_W-1:0]     parent;
      logic [IDX_W-1:0]     buddy;
      logic [STAMP_W-1:0]   stamp;
   } rec_type;

   localparam int REC_W = $bits(rec_type);

   typedef struct packed {
      logic                 clear;
      logic                 valid;
      logic [IDX_W-1:0]     idx;
      logic [ORD_W-1:0]     order;
      logic [ADDR_W-1:0]    offset;
      logic [STAMP_W-1:0]   stamp_now;
   } scan_ctl_type;

   typedef struct packed {
      logic                 first_ok;
      logic [IDX_W-1:0]     first_idx;
      logic                 second_ok;
      logic [IDX_W-1:0]     second_idx;
      logic [CNT_W-1:0]     empty_cnt;
      logic                 best_ok;
      logic [IDX_W-1:0]     best_idx;
      rec_type              best_rec;
      logic                 match_ok;
      logic [IDX_W-1:0]     match_idx;
      rec_type              match_rec;
   } scan_res_type;

   // smallest order whose block holds n pages
   function automatic logic [ORD_W-1:0] order_for(input logic [REQ_W-1:0] n);
      logic [ORD_W-1:0] j;
      j = '0;
      for (int b = 0; b < BIG_W; b++) begin
         if ((BIG_W'(1) << b) < BIG_W'(n)) j = j + 1'b1;
      end
      return j;
   endfunction
endpackage
`default_nettype wire

// ===== hdl/bpa_if.sv =====
// Channel interfaces of the buddy page allocator.
`default_nettype none
interface bpa_req_if;
   logic                             valid;
   logic                             ready;
   logic [bpa_pkg::FUNC_W-1:0]       func;
   logic [bpa_pkg::REQ_W-1:0]        pages_requested;
   logic [bpa_pkg::ADDR_W-1:0]       block_address;
   modport source(output valid, func, pages_requested, block_address, input ready);
   modport sink(input valid, func, pages_requested, block_address, output ready);
endinterface

interface bpa_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [bpa_pkg::STS_W-1:0]        status;
   logic [bpa_pkg::ADDR_W-1:0]       address;
   modport source(output valid, status, address, input ready);
   modport sink(input valid, status, address, output ready);
endinterface

interface bpa_csr_if;
   logic                             valid;
   logic                             ready;
   logic [bpa_pkg::CSR_IDX_W-1:0]    index;
   logic [bpa_pkg::ADDR_W-1:0]       data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/bpa_ram.sv =====
// Block record memory: one write port, one registered read port.
`default_nettype none
module bpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

// ===== hdl/bpa_scan.sv =====
// Record scan unit: empty count, first two empties, oldest free, address match.
`default_nettype none
module bpa_scan (
   input  logic                  clock,
   input  logic                  reset,
   input  bpa_pkg::scan_ctl_type ctl,
   input  bpa_pkg::rec_type      rec,
   output bpa_pkg::scan_res_type res
);
   import bpa_pkg::*;

   scan_res_type         res_ff, res_in;
   logic [STAMP_W-1:0]   best_age_ff, best_age_in;
   logic [STAMP_W-1:0]   age;

   always_comb begin
      res_in      = res_ff;
      best_age_in = best_age_ff;
      age         = ctl.stamp_now - rec.stamp;
      if (ctl.clear) begin
         res_in      = '0;
         best_age_in = '0;
      end else if (ctl.valid) begin
         if (rec.kind == KIND_EMPTY) begin
            res_in.empty_cnt = res_ff.empty_cnt + 1'b1;
            if (!res_ff.first_ok) begin
               res_in.first_ok  = 1'b1;
               res_in.first_idx = ctl.idx;
            end else if (!res_ff.second_ok) begin
               res_in.second_ok  = 1'b1;
               res_in.second_idx = ctl.idx;
            end
         end
         if (rec.kind == KIND_FREE && rec.order == ctl.order &&
             (!res_ff.best_ok || age > best_age_ff)) begin
            res_in.best_ok  = 1'b1;
            res_in.best_idx = ctl.idx;
            res_in.best_rec = rec;
            best_age_in     = age;
         end
         if (rec.kind == KIND_ALLOC && !res_ff.match_ok &&
             ADDR_W'({rec.page, {PAGE_SHIFT_BITS{1'b0}}}) == ctl.offset) begin
            res_in.match_ok  = 1'b1;
            res_in.match_idx = ctl.idx;
            res_in.match_rec = rec;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff      <= '0;
         best_age_ff <= '0;
      end else begin
         res_ff      <= res_in;
         best_age_ff <= best_age_in;
      end
   end

   assign res = res_ff;
endmodule
`default_nettype wire

// ===== hdl/buddy_page_allocator_top.sv =====
// Top level of the buddy page allocator: sequencer, registers, record memory.
//
//   channel   dir   payload                                   taken when
//   req_ch    in    func, pages_requested, block_address      valid & ready
//   rsp_ch    out   status, address                           valid & ready
//   csr_ch    in    index, data                               valid & ready
//
// Every record walk reads the record memory one entry a cycle, through S_SCAN, S_DRAIN and S_EVAL.
// Allocate: 1 to 2*order_count - 1 walks plus S_WR_P, S_WR_L and S_WR_R per split; free: 1 walk
// plus S_RD_BUD, S_CHK, S_WR_CUR and S_LD_PAR per merge step; init: a clearing pass, then
// one layout step per laid-out block and order.
// After reset a clearing pass over all RECORD_DEPTH records runs before the first item is taken.
// req_ch.ready is low while an item is in work or its result waits on rsp_ch.
`default_nettype none
`include "buddy_page_allocator_top_defines.svh"
module buddy_page_allocator_top (
   input logic    clock,
   input logic    reset,
   bpa_req_if.sink   req_ch,
   bpa_rsp_if.source rsp_ch,
   bpa_csr_if.sink   csr_ch
);
   import bpa_pkg::*;

   state_type            state_ff, state_in;
   phase_type            phase_ff, phase_in;
   logic [ADDR_W-1:0]    base_ff;
   logic [PCFG_W-1:0]    pages_cfg_ff;
   logic [OCFG_W-1:0]    orders_cfg_ff;
   logic [STAMP_W-1:0]   sc_ff, sc_in;
   logic [CNT_W-1:0]     idx_ff, idx_in;
   logic                 dvld_ff;
   logic [IDX_W-1:0]     didx_ff;
   logic                 init_ff, init_in;
   logic [ORD_W-1:0]     j_ff, j_in, k_ff, k_in, i_ff, i_in, o_ff, o_in, tgt_ff, tgt_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [PAGE_W-1:0]    page_ff, page_in;
   logic [IDX_W-1:0]     cur_idx_ff, cur_idx_in;
   rec_type              cur_rec_ff, cur_rec_in;
   logic [GUARD_W-1:0]   guard_ff, guard_in;
   logic [ADDR_W-1:0]    off_ff, off_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]    rsp_addr_ff, rsp_addr_in;

   logic                 we;
   logic [IDX_W-1:0]     waddr, raddr;
   rec_type              wdata, rdata;
   logic [REC_W-1:0]     rdata_bits;
   scan_ctl_type         sctl;
   scan_res_type         sres;
   logic                 scan_start;
   logic [ORD_W-1:0]     eo;
   logic [BIG_W-1:0]     max_blk;
   logic [REM_W-1:0]     init_pages;

   bpa_ram #(.WIDTH(REC_W), .DEPTH(RECORD_DEPTH)) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata_bits)
   );
   assign rdata = rec_type'(rdata_bits);

   bpa_scan u_scan (
      .clock (clock),
      .reset (reset),
      .ctl   (sctl),
      .rec   (rdata),
      .res   (sres)
   );

   always_comb begin
      sctl.clear     = scan_start;
      sctl.valid     = dvld_ff;
      sctl.idx       = didx_ff;
      sctl.order     = tgt_ff;
      sctl.offset    = off_ff;
      sctl.stamp_now = sc_ff;
   end

   always_comb begin
      if (orders_cfg_ff == '0) eo = ORD_W'(1);
      else if ({1'b0, orders_cfg_ff} > 5'(MAX_ORDERS)) eo = ORD_W'(MAX_ORDERS);
      else eo = ORD_W'(orders_cfg_ff);
      max_blk = BIG_W'(1) << (eo - 1'b1);
      if ({1'b0, pages_cfg_ff} > 12'(MAX_PAGES)) init_pages = REM_W'(MAX_PAGES);
      else init_pages = REM_W'(pages_cfg_ff);
   end

   assign req_ch.ready   = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign csr_ch.ready   = 1'b1;
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.status  = rsp_status_ff;
   assign rsp_ch.address = rsp_addr_ff;

   always_comb begin
      logic [PAGE_W-1:0] size;
      logic [ORD_W-1:0]  nx;
      logic              merge;

      state_in      = state_ff;
      phase_in      = phase_ff;
      sc_in         = sc_ff;
      idx_in        = idx_ff;
      init_in       = init_ff;
      j_in          = j_ff;
      k_in          = k_ff;
      i_in          = i_ff;
      o_in          = o_ff;
      tgt_in        = tgt_ff;
      rem_in        = rem_ff;
      page_in       = page_ff;
      cur_idx_in    = cur_idx_ff;
      cur_rec_in    = cur_rec_ff;
      guard_in      = guard_ff;
      off_in        = off_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      scan_start    = 1'b0;
      we            = 1'b0;
      waddr         = idx_ff[IDX_W-1:0];
      wdata         = '0;
      raddr         = idx_ff[IDX_W-1:0];
      size          = PAGE_W'(1) << o_ff;
      nx            = '0;
      merge         = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            we     = 1'b1;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == CNT_W'(RECORD_DEPTH - 1)) begin
               idx_in = '0;
               if (!init_ff) begin
                  state_in = S_IDLE;
               end else if (init_pages == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STS_BAD_SIZE;
                  rsp_addr_in   = '0;
                  state_in      = S_IDLE;
               end else begin
                  rem_in   = init_pages;
                  o_in     = eo - 1'b1;
                  page_in  = '0;
                  state_in = S_LAYOUT;
               end
            end
         end
         S_IDLE: begin
            if (req_ch.valid && req_ch.ready) begin
               unique case (func_type'(req_ch.func))
                  FN_INIT: begin
                     sc_in    = '0;
                     idx_in   = '0;
                     init_in  = 1'b1;
                     state_in = S_CLEAR;
                  end
                  FN_ALLOC: begin
                     if (req_ch.pages_requested == '0 ||
                         BIG_W'(req_ch.pages_requested) > max_blk) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STS_BAD_SIZE;
                        rsp_addr_in   = '0;
                     end else begin
                        j_in       = order_for(req_ch.pages_requested);
                        tgt_in     = order_for(req_ch.pages_requested);
                        phase_in   = PH_ALLOC_J;
                        idx_in     = '0;
                        scan_start = 1'b1;
                        state_in   = S_SCAN;
                     end
                  end
                  FN_FREE: begin
                     off_in     = req_ch.block_address - base_ff;
                     phase_in   = PH_FREE;
                     idx_in     = '0;
                     scan_start = 1'b1;
                     state_in   = S_SCAN;
                  end
                  FN_NOP: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STS_OK;
                     rsp_addr_in   = '0;
                  end
               endcase
            end
         end
         S_LAYOUT: begin
            if (idx_ff == CNT_W'(RECORD_DEPTH)) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STS_OK;
               rsp_addr_in   = '0;
               state_in      = S_IDLE;
            end else if (PAGE_W'(rem_ff) >= size) begin
               we              = 1'b1;
               wdata.kind      = KIND_FREE;
               wdata.page      = page_ff;
               wdata.order     = o_ff;
               wdata.stamp     = sc_ff;
               sc_in           = sc_ff + 1'b1;
               rem_in          = rem_ff - REM_W'(size);
               page_in         = page_ff + size;
               idx_in          = idx_ff + 1'b1;
            end else if (o_ff == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STS_OK;
               rsp_addr_in   = '0;
               state_in      = S_IDLE;
            end else begin
               o_in = o_ff - 1'b1;
            end
         end
         S_SCAN: begin
            idx_in = idx_ff + 1'b1;
            if (idx_ff == CNT_W'(RECORD_DEPTH - 1)) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            unique case (phase_ff)
               PH_ALLOC_J, PH_FINAL: begin
                  if (sres.best_ok) begin
                     we            = 1'b1;
                     waddr         = sres.best_idx;
                     wdata         = sres.best_rec;
                     wdata.kind    = KIND_ALLOC;
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STS_OK;
                     rsp_addr_in   = base_ff +
                        ADDR_W'({sres.best_rec.page, {PAGE_SHIFT_BITS{1'b0}}});
                     state_in      = S_IDLE;
                  end else if (phase_ff == PH_FINAL || j_ff + 1'b1 >= eo) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STS_NO_BLOCK;
                     rsp_addr_in   = '0;
                     state_in      = S_IDLE;
                  end else begin
                     k_in       = j_ff + 1'b1;
                     tgt_in     = j_ff + 1'b1;
                     phase_in   = PH_ALLOC_K;
                     idx_in     = '0;
                     scan_start = 1'b1;
                     state_in   = S_SCAN;
                  end
               end
               PH_ALLOC_K: begin
                  if (sres.best_ok) begin
                     if (sres.empty_cnt < CNT_W'({k_ff - j_ff, 1'b0})) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STS_NO_BLOCK;
                        rsp_addr_in   = '0;
                        state_in      = S_IDLE;
                     end else begin
                        i_in     = k_ff;
                        state_in = S_WR_P;
                     end
                  end else if (k_ff + 1'b1 >= eo) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STS_NO_BLOCK;
                     rsp_addr_in   = '0;
                     state_in      = S_IDLE;
                  end else begin
                     k_in       = k_ff + 1'b1;
                     tgt_in     = k_ff + 1'b1;
                     idx_in     = '0;
                     scan_start = 1'b1;
                     state_in   = S_SCAN;
                  end
               end
               PH_SPLIT: begin
                  state_in = S_WR_P;
               end
               PH_FREE: begin
                  if (!sres.match_ok) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STS_NOT_ALLOC;
                     rsp_addr_in   = '0;
                     state_in      = S_IDLE;
                  end else begin
                     cur_idx_in = sres.match_idx;
                     cur_rec_in = sres.match_rec;
                     guard_in   = '0;
                     state_in   = S_RD_BUD;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_WR_P: begin
            we         = 1'b1;
            waddr      = sres.best_idx;
            wdata      = sres.best_rec;
            wdata.kind = KIND_PARENT;
            state_in   = S_WR_L;
         end
         S_WR_L: begin
            we              = 1'b1;
            waddr           = sres.first_idx;
            wdata.kind      = KIND_FREE;
            wdata.has_buddy = 1'b1;
            wdata.page      = sres.best_rec.page;
            wdata.order     = i_ff - 1'b1;
            wdata.parent    = sres.best_idx;
            wdata.buddy     = sres.second_idx;
            wdata.stamp     = sc_ff;
            sc_in           = sc_ff + 1'b1;
            state_in        = S_WR_R;
         end
         S_WR_R: begin
            nx              = i_ff - 1'b1;
            we              = 1'b1;
            waddr           = sres.second_idx;
            wdata.kind      = KIND_FREE;
            wdata.has_buddy = 1'b1;
            wdata.page      = sres.best_rec.page + (PAGE_W'(1) << nx);
            wdata.order     = nx;
            wdata.parent    = sres.best_idx;
            wdata.buddy     = sres.first_idx;
            wdata.stamp     = sc_ff;
            sc_in           = sc_ff + 1'b1;
            i_in            = nx;
            tgt_in          = nx;
            phase_in        = (nx == j_ff) ? PH_FINAL : PH_SPLIT;
            idx_in          = '0;
            scan_start      = 1'b1;
            state_in        = S_SCAN;
         end
         S_RD_BUD: begin
            raddr    = cur_rec_ff.buddy;
            state_in = S_CHK;
         end
         S_CHK: begin
            merge = cur_rec_ff.has_buddy && rdata.kind == KIND_FREE &&
                    CNT_W'(cur_rec_ff.buddy) < CNT_W'(RECORD_DEPTH) &&
                    CNT_W'(cur_rec_ff.parent) < CNT_W'(RECORD_DEPTH) &&
                    guard_ff <= GUARD_W'(MAX_ORDERS + 1);
            if (merge) begin
               we       = 1'b1;
               waddr    = cur_rec_ff.buddy;
               state_in = S_WR_CUR;
            end else begin
               state_in = S_MKFREE;
            end
         end
         S_WR_CUR: begin
            we       = 1'b1;
            waddr    = cur_idx_ff;
            raddr    = cur_rec_ff.parent;
            state_in = S_LD_PAR;
         end
         S_LD_PAR: begin
            cur_idx_in = cur_rec_ff.parent;
            cur_rec_in = rdata;
            guard_in   = guard_ff + 1'b1;
            state_in   = S_RD_BUD;
         end
         S_MKFREE: begin
            we            = 1'b1;
            waddr         = cur_idx_ff;
            wdata         = cur_rec_ff;
            wdata.kind    = KIND_FREE;
            wdata.stamp   = sc_ff;
            sc_in         = sc_ff + 1'b1;
            rsp_valid_in  = 1'b1;
            rsp_status_in = STS_OK;
            rsp_addr_in   = '0;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         phase_ff      <= PH_ALLOC_J;
         idx_ff        <= '0;
         init_ff       <= 1'b0;
         sc_ff         <= '0;
         dvld_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         base_ff       <= BASE_RESET;
         pages_cfg_ff  <= PAGES_RESET;
         orders_cfg_ff <= ORDERS_RESET;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         idx_ff       <= idx_in;
         init_ff      <= init_in;
         sc_ff        <= sc_in;
         dvld_ff      <= (state_ff == S_SCAN);
         rsp_valid_ff <= rsp_valid_in;
         if (csr_ch.valid && csr_ch.ready) begin
            unique case (csr_ch.index)
               CSR_BASE:   base_ff       <= csr_ch.data;
               CSR_PAGES:  pages_cfg_ff  <= csr_ch.data[PCFG_W-1:0];
               CSR_ORDERS: orders_cfg_ff <= csr_ch.data[OCFG_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      didx_ff       <= idx_ff[IDX_W-1:0];
      j_ff          <= j_in;
      k_ff          <= k_in;
      i_ff          <= i_in;
      o_ff          <= o_in;
      tgt_ff        <= tgt_in;
      rem_ff        <= rem_in;
      page_ff       <= page_in;
      cur_idx_ff    <= cur_idx_in;
      cur_rec_ff    <= cur_rec_in;
      guard_ff      <= guard_in;
      off_ff        <= off_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

   `BPA_ASSERT(a_err_zero_addr, rsp_valid_ff && (rsp_status_ff != STS_OK) |-> rsp_addr_ff == '0)
   `BPA_ASSERT(a_stamp_step, (sc_ff != $past(sc_ff)) |-> (sc_ff == $past(sc_ff) + 1'b1) || (sc_ff == '0))
   `BPA_ASSERT(a_drain_eval, (state_ff == S_DRAIN) |=> (state_ff == S_EVAL))
   `BPA_ASSERT_ALWAYS(a_busy_not_ready, (state_ff != S_IDLE) |-> !req_ch.ready)
endmodule
`default_nettype wire
